/* hw/rtl/lav_pkg.sv */
// Package for the look-at view matrix unit: word formats, pipeline latencies
// and the fixed-point truncate/saturate helpers. No dependencies.

package lav_pkg;

  localparam int W = 32;               // word bits
  localparam int F = 16;               // fraction bits
  localparam int IN_DATA_W  = 9 * W;
  localparam int OUT_DATA_W = 12 * W;

  localparam int DIF_W = W + 1;        // target - eye
  localparam int MAG_W = W;            // |target - eye| and |cross|
  localparam int S1_W  = 2 * W + 2;    // sum of squares, view vector
  localparam int S2_W  = 2 * W;        // sum of squares, cross vector
  localparam int M1_W  = S1_W / 2;
  localparam int M2_W  = S2_W / 2;
  localparam int NUM_W = MAG_W + F;
  localparam int Q_W   = F + 1;        // normalized component magnitude <= 1.0
  localparam int AX_W  = F + 2;        // signed unit axis component
  localparam int CAM_W = F + 3;        // signed camera up component
  localparam int PW    = W + AX_W;     // word x axis product
  localparam int CP_W  = 2 * AX_W;     // axis x axis product
  localparam int EC_W  = W + CAM_W;    // word x camera up product
  localparam int ACC_W = W + F + 6;    // accumulator for sums before truncation

  localparam int SQ1_LAT  = S1_W / 2;
  localparam int SQ2_LAT  = S2_W / 2;
  localparam int DIV_LAT  = Q_W;
  localparam int PIPE_LAT = 13 + SQ1_LAT + SQ2_LAT + 2 * DIV_LAT;

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] FRAC_ONES = {{(ACC_W-F){1'b0}}, {F{1'b1}}};

  typedef logic signed [W-1:0] word_t;

  // divide by 2^F, rounding toward zero
  function automatic logic signed [ACC_W-1:0] trunc_fx(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] bias;
    bias = v[ACC_W-1] ? FRAC_ONES : '0;
    return (v + bias) >>> F;
  endfunction

  function automatic word_t sat_word(input logic signed [ACC_W-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic word_t trunc_sat(input logic signed [ACC_W-1:0] v);
    return sat_word(trunc_fx(v));
  endfunction

  function automatic word_t neg_trunc_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = trunc_fx(v);
    return sat_word(-t);
  endfunction

endpackage

/* hw/rtl/lav_isqrt.sv */
// Pipelined integer square root, one root bit per stage (floor result).
// Stand-alone.

module lav_isqrt #(
  parameter int OP_W = 66
) (
  input  logic              clk,
  input  logic              en,
  input  logic [OP_W-1:0]   op,
  output logic [OP_W/2-1:0] root
);

  localparam int RT_W  = OP_W / 2;
  localparam int REM_W = RT_W + 3;

  logic [OP_W-1:0]  op_r    [RT_W];
  logic [REM_W-1:0] rem_r   [RT_W];
  logic [RT_W-1:0]  root_r  [RT_W];
  logic [OP_W-1:0]  op_nxt  [RT_W];
  logic [REM_W-1:0] rem_nxt [RT_W];
  logic [RT_W-1:0]  root_nxt[RT_W];

  always_comb begin
    logic [OP_W-1:0]  opv;
    logic [REM_W-1:0] remv;
    logic [RT_W-1:0]  rootv;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    for (int k = 0; k < RT_W; k++) begin
      if (k == 0) begin
        opv   = op;
        remv  = '0;
        rootv = '0;
      end else begin
        opv   = op_r[k-1];
        remv  = rem_r[k-1];
        rootv = root_r[k-1];
      end
      rem_sh      = {remv[REM_W-3:0], opv[OP_W-1 -: 2]};
      trial       = REM_W'({rootv, 2'b01});
      ge          = (rem_sh >= trial);
      op_nxt[k]   = opv << 2;
      rem_nxt[k]  = ge ? rem_sh - trial : rem_sh;
      root_nxt[k] = {rootv[RT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RT_W; k++) begin
        op_r[k]   <= op_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root = root_r[RT_W-1];

endmodule

/* hw/rtl/lav_div.sv */
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// The quotient must fit in Q_W bits.

module lav_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33,
  parameter int Q_W   = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [DEN_W-1:0] rem_r   [Q_W];
  logic [Q_W-1:0]   nlo_r   [Q_W];
  logic [DEN_W-1:0] den_r   [Q_W];
  logic [Q_W-1:0]   quo_r   [Q_W];
  logic [DEN_W-1:0] rem_nxt [Q_W];
  logic [Q_W-1:0]   nlo_nxt [Q_W];
  logic [DEN_W-1:0] den_nxt [Q_W];
  logic [Q_W-1:0]   quo_nxt [Q_W];

  always_comb begin
    logic [DEN_W-1:0] remv;
    logic [Q_W-1:0]   nlov;
    logic [DEN_W-1:0] denv;
    logic [Q_W-1:0]   quov;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        // high part is below den because the quotient fits in Q_W bits
        remv = DEN_W'(num >> Q_W);
        nlov = num[Q_W-1:0];
        denv = den;
        quov = '0;
      end else begin
        remv = rem_r[k-1];
        nlov = nlo_r[k-1];
        denv = den_r[k-1];
        quov = quo_r[k-1];
      end
      rem_sh     = {remv, nlov[Q_W-1]};
      diff       = rem_sh - {1'b0, denv};
      ge         = (rem_sh >= {1'b0, denv});
      rem_nxt[k] = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      nlo_nxt[k] = nlov << 1;
      den_nxt[k] = denv;
      quo_nxt[k] = {quov[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        nlo_r[k] <= nlo_nxt[k];
        den_r[k] <= den_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule

/* hw/rtl/look_at_view_matrix_unit.sv */
// Look-at view matrix unit, top level: stream ports, pipeline control and axis math.
// Depends on lav_pkg, lav_isqrt and lav_div.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  in_     | in  | in_tvalid/tready   | eye xyz, target xyz, up xyz (Q16.16)
//  out_    | out | out_tvalid/tready  | right, up axis, back, three shifts
//
// One transaction enters per cycle while the output is not stalled; the pipeline holds
// two square roots of 33 and 32 stages and two banks of three 17-stage dividers.
// One enable moves every stage; it drops only while the output register holds a
// result that is not taken, so a stall loses and repeats nothing.
// rst_n (synchronous) clears the valid chain only.

module look_at_view_matrix_unit
  import lav_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // right_x/y/z, upaxis_x/y/z, back_x/y/z, shift_right, shift_up, shift_back
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef logic [2:0][W-1:0]     word3_t;
  typedef logic [2:0][AX_W-1:0]  ax3_t;
  typedef logic [2:0][MAG_W-1:0] mag3_t;

  typedef struct packed {
    word3_t     eye;
    word3_t     up;
    logic [2:0] neg;
    mag3_t      mag;
  } side1_t;

  typedef struct packed {
    word3_t     eye;
    word3_t     up;
    logic [2:0] neg;
    logic       zero;
  } side2_t;

  typedef struct packed {
    word3_t     eye;
    ax3_t       back;
    logic       zero;
    logic [2:0] neg;
    mag3_t      mag;
  } side3_t;

  typedef struct packed {
    word3_t     eye;
    ax3_t       back;
    logic [2:0] neg;
    logic       zero;
  } side4_t;

  function automatic logic signed [PW-1:0] mul_wa(input logic signed [W-1:0] a,
                                                  input logic signed [AX_W-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  function automatic logic signed [CP_W-1:0] mul_aa(input logic signed [AX_W-1:0] a,
                                                    input logic signed [AX_W-1:0] b);
    return CP_W'(a) * CP_W'(b);
  endfunction

  function automatic logic signed [EC_W-1:0] mul_wc(input logic signed [W-1:0] a,
                                                    input logic signed [CAM_W-1:0] b);
    return EC_W'(a) * EC_W'(b);
  endfunction

  logic                en;
  logic [PIPE_LAT-1:0] vld_r;

  assign en         = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  // ---------------- view vector and its length ----------------
  word3_t                   a_eye_r, a_up_r;
  logic signed [DIF_W-1:0]  a_d_r [3];
  word3_t                   b_eye_r, b_up_r;
  logic [S1_W-1:0]          b_sq_r [3];
  logic [2:0]               b_neg_r;
  mag3_t                    b_mag_r;
  logic [S1_W-1:0]          c_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_eye_r[i] <= in_tdata[i*W +: W];
        a_up_r[i]  <= in_tdata[(i+6)*W +: W];
        a_d_r[i]   <= DIF_W'($signed(in_tdata[(i+3)*W +: W]))
                    - DIF_W'($signed(in_tdata[i*W +: W]));
        b_sq_r[i]  <= S1_W'(a_d_r[i]) * S1_W'(a_d_r[i]);
        b_neg_r[i] <= a_d_r[i][DIF_W-1];
        b_mag_r[i] <= a_d_r[i][DIF_W-1] ? MAG_W'(-a_d_r[i]) : MAG_W'(a_d_r[i]);
      end
      b_eye_r <= a_eye_r;
      b_up_r  <= a_up_r;
      c_s1_r  <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
    end
  end

  side1_t side1_nxt;
  side1_t sq1_dly_r [SQ1_LAT+1];
  side1_t s1_out;
  logic [M1_W-1:0] m1;

  assign side1_nxt = '{eye: b_eye_r, up: b_up_r, neg: b_neg_r, mag: b_mag_r};
  assign s1_out    = sq1_dly_r[SQ1_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_dly_r[0] <= side1_nxt;
      for (int i = 1; i <= SQ1_LAT; i++) begin
        sq1_dly_r[i] <= sq1_dly_r[i-1];
      end
    end
  end

  lav_isqrt #(.OP_W(S1_W)) u_sqrt1 (
    .clk  (clk),
    .en   (en),
    .op   (c_s1_r),
    .root (m1)
  );

  logic [Q_W-1:0] q1 [3];

  for (genvar g = 0; g < 3; g++) begin : g_div1
    lav_div #(.NUM_W(NUM_W), .DEN_W(M1_W), .Q_W(Q_W)) u_div (
      .clk (clk),
      .en  (en),
      .num ({s1_out.mag[g], {F{1'b0}}}),
      .den (m1),
      .quo (q1[g])
    );
  end

  side2_t side2_nxt;
  side2_t d1_dly_r [DIV_LAT];
  side2_t s2_out;

  assign side2_nxt = '{eye: s1_out.eye, up: s1_out.up, neg: s1_out.neg,
                       zero: (m1 == '0)};
  assign s2_out    = d1_dly_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d1_dly_r[0] <= side2_nxt;
      for (int i = 1; i < DIV_LAT; i++) begin
        d1_dly_r[i] <= d1_dly_r[i-1];
      end
    end
  end

  // ---------------- back axis, cross with up ----------------
  word3_t                 e_eye_r, e_up_r;
  ax3_t                   e_back_r;
  logic                   e_zero_r;
  word3_t                 f_eye_r;
  ax3_t                   f_back_r;
  logic                   f_zero_r;
  logic signed [PW-1:0]   f_p_r [6];
  word3_t                 g_eye_r;
  ax3_t                   g_back_r;
  logic                   g_zero_r;
  word_t                  g_c_r [3];
  word3_t                 h_eye_r;
  ax3_t                   h_back_r;
  logic                   h_zero_r;
  logic [S2_W-1:0]        h_sq_r [3];
  logic [2:0]             h_neg_r;
  mag3_t                  h_mag_r;
  logic [S2_W-1:0]        i_s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // back is the negated normalized view vector
      for (int i = 0; i < 3; i++) begin
        e_back_r[i] <= s2_out.neg[i] ? AX_W'(q1[i]) : -AX_W'(q1[i]);
      end
      e_eye_r  <= s2_out.eye;
      e_up_r   <= s2_out.up;
      e_zero_r <= s2_out.zero;

      f_p_r[0] <= mul_wa(e_up_r[1], e_back_r[2]);
      f_p_r[1] <= mul_wa(e_up_r[2], e_back_r[1]);
      f_p_r[2] <= mul_wa(e_up_r[2], e_back_r[0]);
      f_p_r[3] <= mul_wa(e_up_r[0], e_back_r[2]);
      f_p_r[4] <= mul_wa(e_up_r[0], e_back_r[1]);
      f_p_r[5] <= mul_wa(e_up_r[1], e_back_r[0]);
      f_eye_r  <= e_eye_r;
      f_back_r <= e_back_r;
      f_zero_r <= e_zero_r;

      for (int i = 0; i < 3; i++) begin
        g_c_r[i] <= trunc_sat(ACC_W'(f_p_r[2*i]) - ACC_W'(f_p_r[2*i+1]));
      end
      g_eye_r  <= f_eye_r;
      g_back_r <= f_back_r;
      g_zero_r <= f_zero_r;

      for (int i = 0; i < 3; i++) begin
        h_sq_r[i]  <= S2_W'(g_c_r[i]) * S2_W'(g_c_r[i]);
        h_neg_r[i] <= g_c_r[i][W-1];
        h_mag_r[i] <= g_c_r[i][W-1] ? MAG_W'(-g_c_r[i]) : MAG_W'(g_c_r[i]);
      end
      h_eye_r  <= g_eye_r;
      h_back_r <= g_back_r;
      h_zero_r <= g_zero_r;

      i_s2_r <= h_sq_r[0] + h_sq_r[1] + h_sq_r[2];
    end
  end

  side3_t side3_nxt;
  side3_t sq2_dly_r [SQ2_LAT+1];
  side3_t s3_out;
  logic [M2_W-1:0] m2;

  assign side3_nxt = '{eye: h_eye_r, back: h_back_r, zero: h_zero_r,
                       neg: h_neg_r, mag: h_mag_r};
  assign s3_out    = sq2_dly_r[SQ2_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sq2_dly_r[0] <= side3_nxt;
      for (int i = 1; i <= SQ2_LAT; i++) begin
        sq2_dly_r[i] <= sq2_dly_r[i-1];
      end
    end
  end

  lav_isqrt #(.OP_W(S2_W)) u_sqrt2 (
    .clk  (clk),
    .en   (en),
    .op   (i_s2_r),
    .root (m2)
  );

  logic [Q_W-1:0] q2 [3];

  for (genvar g = 0; g < 3; g++) begin : g_div2
    lav_div #(.NUM_W(NUM_W), .DEN_W(M2_W), .Q_W(Q_W)) u_div (
      .clk (clk),
      .en  (en),
      .num ({s3_out.mag[g], {F{1'b0}}}),
      .den (m2),
      .quo (q2[g])
    );
  end

  side4_t side4_nxt;
  side4_t d2_dly_r [DIV_LAT];
  side4_t s4_out;

  // a zero cross vector (up along the view line) blanks the result
  assign side4_nxt = '{eye: s3_out.eye, back: s3_out.back, neg: s3_out.neg,
                       zero: s3_out.zero || (m2 == '0)};
  assign s4_out    = d2_dly_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d2_dly_r[0] <= side4_nxt;
      for (int i = 1; i < DIV_LAT; i++) begin
        d2_dly_r[i] <= d2_dly_r[i-1];
      end
    end
  end

  // ---------------- right, camera up, translations ----------------
  word3_t                  j_eye_r, k_eye_r, l_eye_r;
  ax3_t                    j_right_r, k_right_r, l_right_r, m_right_r;
  ax3_t                    j_back_r, k_back_r, l_back_r, m_back_r;
  logic                    j_zero_r, k_zero_r, l_zero_r, m_zero_r;
  logic signed [CP_W-1:0]  k_cp_r [6];
  logic signed [PW-1:0]    k_er_r [3];
  logic signed [PW-1:0]    k_eb_r [3];
  logic signed [CAM_W-1:0] l_cam_r [3];
  logic signed [CAM_W-1:0] m_cam_r [3];
  word_t                   l_sr_r, l_sb_r, m_sr_r, m_sb_r;
  logic signed [EC_W-1:0]  m_ec_r [3];
  word_t                   cam_word;
  logic [OUT_DATA_W-1:0]   n_data_nxt;
  logic [OUT_DATA_W-1:0]   n_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        j_right_r[i] <= s4_out.neg[i] ? -AX_W'(q2[i]) : AX_W'(q2[i]);
      end
      j_eye_r  <= s4_out.eye;
      j_back_r <= s4_out.back;
      j_zero_r <= s4_out.zero;

      k_cp_r[0] <= mul_aa(j_back_r[1], j_right_r[2]);
      k_cp_r[1] <= mul_aa(j_back_r[2], j_right_r[1]);
      k_cp_r[2] <= mul_aa(j_back_r[2], j_right_r[0]);
      k_cp_r[3] <= mul_aa(j_back_r[0], j_right_r[2]);
      k_cp_r[4] <= mul_aa(j_back_r[0], j_right_r[1]);
      k_cp_r[5] <= mul_aa(j_back_r[1], j_right_r[0]);
      for (int i = 0; i < 3; i++) begin
        k_er_r[i] <= mul_wa(j_eye_r[i], j_right_r[i]);
        k_eb_r[i] <= mul_wa(j_eye_r[i], j_back_r[i]);
      end
      k_eye_r   <= j_eye_r;
      k_right_r <= j_right_r;
      k_back_r  <= j_back_r;
      k_zero_r  <= j_zero_r;

      for (int i = 0; i < 3; i++) begin
        // camera up magnitude stays below 2^(F+1), so the narrowing is exact
        l_cam_r[i] <= CAM_W'(trunc_sat(ACC_W'(k_cp_r[2*i]) - ACC_W'(k_cp_r[2*i+1])));
      end
      l_sr_r    <= neg_trunc_sat(ACC_W'(k_er_r[0]) + ACC_W'(k_er_r[1]) + ACC_W'(k_er_r[2]));
      l_sb_r    <= neg_trunc_sat(ACC_W'(k_eb_r[0]) + ACC_W'(k_eb_r[1]) + ACC_W'(k_eb_r[2]));
      l_eye_r   <= k_eye_r;
      l_right_r <= k_right_r;
      l_back_r  <= k_back_r;
      l_zero_r  <= k_zero_r;

      for (int i = 0; i < 3; i++) begin
        m_ec_r[i]  <= mul_wc(l_eye_r[i], l_cam_r[i]);
        m_cam_r[i] <= l_cam_r[i];
      end
      m_sr_r    <= l_sr_r;
      m_sb_r    <= l_sb_r;
      m_right_r <= l_right_r;
      m_back_r  <= l_back_r;
      m_zero_r  <= l_zero_r;

      n_data_r <= n_data_nxt;
    end
  end

  always_comb begin
    n_data_nxt = '0;
    cam_word   = '0;
    if (!m_zero_r) begin
      for (int i = 0; i < 3; i++) begin
        cam_word                     = W'(m_cam_r[i]);
        n_data_nxt[i*W +: W]         = W'($signed(m_right_r[i]));
        n_data_nxt[(i+3)*W +: W]     = cam_word;
        n_data_nxt[(i+6)*W +: W]     = W'($signed(m_back_r[i]));
      end
      n_data_nxt[9*W +: W]  = m_sr_r;
      n_data_nxt[10*W +: W] = neg_trunc_sat(ACC_W'(m_ec_r[0]) + ACC_W'(m_ec_r[1])
                                            + ACC_W'(m_ec_r[2]));
      n_data_nxt[11*W +: W] = m_sb_r;
    end
  end

  assign out_tdata = n_data_r;

  // ---------------- checks ----------------
  localparam logic signed [W-1:0] AX_ONE = W'(1) << F;

  logic axes_ok;

  always_comb begin
    axes_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ($signed(out_tdata[i*W +: W]) > AX_ONE || $signed(out_tdata[i*W +: W]) < -AX_ONE) begin
        axes_ok = 1'b0;
      end
      if ($signed(out_tdata[(i+6)*W +: W]) > AX_ONE
          || $signed(out_tdata[(i+6)*W +: W]) < -AX_ONE) begin
        axes_ok = 1'b0;
      end
    end
  end

  ap_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  ap_unit_axes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> axes_ok)
    else $error("right or back component beyond unit length");

  ap_blank_all: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[6*W +: 3*W] == '0) |-> (out_tdata == '0))
    else $error("zero back axis with nonzero fields");

endmodule
